// ===== rtl/core/c_include_config_scanner_top_defines.svh =====
// Assertion macros for the include and config scanner.
// Each macro takes a label, a clock, a reset and two expressions.
`ifndef C_INCLUDE_CONFIG_SCANNER_TOP_DEFINES_SVH
`define C_INCLUDE_CONFIG_SCANNER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CICS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cics: implication check failed");
`define CICS_ASSERT_LAT2(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("cics: two cycle check failed");
`else
`define CICS_ASSERT_IMP(label, clk, rst, ante, cons)
`define CICS_ASSERT_LAT2(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/cics_pkg.sv =====
`default_nettype none

package cics_pkg;

   // One input beat: a source byte or the end of a file.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } req_beat_type;

   // One result beat.
   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] name_byte;
      logic       std_include;
      logic       is_config_header;
      logic       config_missing;
      logic       needs_config_flag;
      logic       has_config_flag;
   } rsp_beat_type;

   // A byte after classification, as it sits in the queue.
   typedef struct packed {
      logic [7:0] data;
      logic       eof;
      logic       nl;
      logic       slash;
      logic       star;
      logic       dquote;
      logic       squote;
      logic       hash;
      logic       bslash;
      logic       blank;
      logic       lt;
      logic       gt;
      logic       underscore;
      logic       lower;
      logic       upper;
   } cls_type;

   localparam logic [2:0] EV_NONE       = 3'd0;
   localparam logic [2:0] EV_NAME_BYTE  = 3'd1;
   localparam logic [2:0] EV_NAME_END   = 3'd2;
   localparam logic [2:0] EV_NAME_DROP  = 3'd3;
   localparam logic [2:0] EV_CONFIG_USE = 3'd4;
   localparam logic [2:0] EV_FILE_END   = 3'd5;

   localparam logic [7:0] CH_NL         = 8'h0a;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_DQUOTE     = 8'h22;
   localparam logic [7:0] CH_HASH       = 8'h23;
   localparam logic [7:0] CH_SQUOTE     = 8'h27;
   localparam logic [7:0] CH_STAR       = 8'h2a;
   localparam logic [7:0] CH_SLASH      = 8'h2f;
   localparam logic [7:0] CH_LT         = 8'h3c;
   localparam logic [7:0] CH_GT         = 8'h3e;
   localparam logic [7:0] CH_BSLASH     = 8'h5c;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5f;

   // Length of the config header name.
   localparam logic [3:0] HDR_LEN = 4'd14;

   // Scanner states, one-hot.
   typedef enum logic [27:0] {
      ST_NORMAL     = 28'd1 << 0,
      ST_SLASH      = 28'd1 << 1,
      ST_STR        = 28'd1 << 2,
      ST_STR_ESC    = 28'd1 << 3,
      ST_CHR        = 28'd1 << 4,
      ST_CHR_ESC    = 28'd1 << 5,
      ST_CMT        = 28'd1 << 6,
      ST_CMT_STAR   = 28'd1 << 7,
      ST_PRE        = 28'd1 << 8,
      ST_SKIP       = 28'd1 << 9,
      ST_SKIP_ESC   = 28'd1 << 10,
      ST_PRE_I      = 28'd1 << 11,
      ST_INC_C      = 28'd1 << 12,
      ST_INC_L      = 28'd1 << 13,
      ST_INC_U      = 28'd1 << 14,
      ST_INC_D      = 28'd1 << 15,
      ST_INC_E      = 28'd1 << 16,
      ST_INC_LINE   = 28'd1 << 17,
      ST_LOCAL_NAME = 28'd1 << 18,
      ST_STD_NAME   = 28'd1 << 19,
      ST_IF_START   = 28'd1 << 20,
      ST_IF_MID     = 28'd1 << 21,
      ST_CF_O       = 28'd1 << 22,
      ST_CF_N       = 28'd1 << 23,
      ST_CF_F       = 28'd1 << 24,
      ST_CF_I       = 28'd1 << 25,
      ST_CF_G       = 28'd1 << 26,
      ST_CF_US      = 28'd1 << 27
   } state_type;

   // Character of the config header name at a given position.
   function automatic logic [7:0] hdr_char(input logic [3:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0:    ch = "l";
         4'd1:    ch = "i";
         4'd2:    ch = "n";
         4'd3:    ch = "u";
         4'd4:    ch = "x";
         4'd5:    ch = "/";
         4'd6:    ch = "c";
         4'd7:    ch = "o";
         4'd8:    ch = "n";
         4'd9:    ch = "f";
         4'd10:   ch = "i";
         4'd11:   ch = "g";
         4'd12:   ch = ".";
         4'd13:   ch = "h";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cics_front.sv =====
`default_nettype none

module cics_front (
   input  wire cics_pkg::req_beat_type req_beat,
   output cics_pkg::cls_type           cls
);
   import cics_pkg::*;

   logic [7:0] b;

   assign b = req_beat.data_byte;

   // Decode the byte classes the scanner branches on, so the back end
   // only sees single-bit flags for them.
   always_comb begin
      cls            = '0;
      cls.data       = b;
      cls.eof        = req_beat.end_of_file;
      cls.nl         = (b == CH_NL);
      cls.slash      = (b == CH_SLASH);
      cls.star       = (b == CH_STAR);
      cls.dquote     = (b == CH_DQUOTE);
      cls.squote     = (b == CH_SQUOTE);
      cls.hash       = (b == CH_HASH);
      cls.bslash     = (b == CH_BSLASH);
      cls.blank      = (b == CH_SPACE) || (b == CH_TAB);
      cls.lt         = (b == CH_LT);
      cls.gt         = (b == CH_GT);
      cls.underscore = (b == CH_UNDERSCORE);
      cls.lower      = (b >= "a") && (b <= "z");
      cls.upper      = (b >= "A") && (b <= "Z");
   end

endmodule

`default_nettype wire

// ===== rtl/core/cics_queue.sv =====
`default_nettype none

module cics_queue #(
   parameter int DEPTH = 2
) (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic push,
   input  wire cics_pkg::cls_type push_data,
   input  wire                logic pop,
   output logic               full,
   output logic               not_empty,
   output cics_pkg::cls_type  head
);
   import cics_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cls_type entry_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = PTR_W'(ptr + PTR_W'(1));
      end
      return nxt;
   endfunction

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + CNT_W'(1));
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cics_back.sv =====
`default_nettype none

module cics_back (
   input  wire                     logic clock,
   input  wire                     logic reset,
   input  wire                     logic item_valid,
   input  wire cics_pkg::cls_type  item,
   output logic                    item_take,
   output logic                    rsp_valid,
   input  wire                     logic rsp_stall,
   output cics_pkg::rsp_beat_type  rsp_beat
);
   import cics_pkg::*;

   state_type    state_ff, state_in;
   logic         needs_ff, needs_in;
   logic         has_ff, has_in;
   logic [3:0]   pos_ff, pos_in;
   logic         mis_ff, mis_in;
   logic         std_ff, std_in;
   logic         rsp_valid_ff;
   rsp_beat_type rsp_beat_ff, rsp_beat_in;
   logic         hit;

   function automatic state_type from_normal(input cls_type c);
      state_type ns;
      if (c.slash) begin
         ns = ST_SLASH;
      end else if (c.dquote) begin
         ns = ST_STR;
      end else if (c.squote) begin
         ns = ST_CHR;
      end else if (c.hash) begin
         ns = ST_PRE;
      end else begin
         ns = ST_NORMAL;
      end
      return ns;
   endfunction

   function automatic state_type from_skip(input cls_type c);
      state_type ns;
      if (c.nl) begin
         ns = ST_NORMAL;
      end else if (c.bslash) begin
         ns = ST_SKIP_ESC;
      end else begin
         ns = ST_SKIP;
      end
      return ns;
   endfunction

   function automatic state_type from_mid(input cls_type c);
      state_type ns;
      if (c.nl) begin
         ns = ST_NORMAL;
      end else if (c.underscore || c.lower || c.upper) begin
         ns = ST_IF_MID;
      end else begin
         ns = ST_IF_START;
      end
      return ns;
   endfunction

   function automatic state_type from_cmt(input cls_type c);
      return c.star ? ST_CMT_STAR : ST_CMT;
   endfunction

   // Expect one letter of a keyword; on a miss, fall back to the line
   // skipper or to the word scanner of an if line.
   function automatic state_type expect_ch(input cls_type c, input logic [7:0] want,
                                           input state_type next_ok, input logic cfg);
      state_type ns;
      if (c.data == want) begin
         ns = next_ok;
      end else if (cfg) begin
         ns = from_mid(c);
      end else begin
         ns = from_skip(c);
      end
      return ns;
   endfunction

   // A new item moves on whenever the output register is free or drains.
   assign item_take = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;
   assign hit       = !mis_ff && (pos_ff == HDR_LEN);

   always_comb begin
      state_in    = state_ff;
      needs_in    = needs_ff;
      has_in      = has_ff;
      pos_in      = pos_ff;
      mis_in      = mis_ff;
      std_in      = std_ff;
      rsp_beat_in = '0;

      if (item.eof) begin
         rsp_beat_in.event_res         = EV_FILE_END;
         rsp_beat_in.needs_config_flag = needs_ff;
         rsp_beat_in.has_config_flag   = has_ff;
         state_in = ST_NORMAL;
         needs_in = 1'b0;
         has_in   = 1'b0;
         pos_in   = '0;
         mis_in   = 1'b0;
         std_in   = 1'b0;
      end else begin
         case (state_ff)
            ST_NORMAL:   state_in = from_normal(item);
            ST_SLASH:    state_in = item.star ? ST_CMT : from_normal(item);
            ST_STR: begin
               state_in = item.dquote ? ST_NORMAL : (item.bslash ? ST_STR_ESC : ST_STR);
            end
            ST_STR_ESC:  state_in = ST_STR;
            ST_CHR: begin
               state_in = item.squote ? ST_NORMAL : (item.bslash ? ST_CHR_ESC : ST_CHR);
            end
            ST_CHR_ESC:  state_in = ST_CHR;
            ST_CMT:      state_in = from_cmt(item);
            ST_CMT_STAR: state_in = item.slash ? ST_NORMAL : from_cmt(item);
            ST_PRE: begin
               if (item.nl) begin
                  state_in = ST_NORMAL;
               end else if (item.blank) begin
                  state_in = ST_PRE;
               end else if (item.data == "i") begin
                  state_in = ST_PRE_I;
               end else begin
                  state_in = ST_SKIP;
               end
            end
            ST_SKIP:     state_in = from_skip(item);
            ST_SKIP_ESC: state_in = ST_SKIP;
            ST_PRE_I: begin
               if (item.data == "f") begin
                  state_in = needs_ff ? ST_SKIP : ST_IF_START;
               end else if (item.data == "n") begin
                  state_in = ST_INC_C;
               end else begin
                  state_in = from_skip(item);
               end
            end
            ST_INC_C:    state_in = expect_ch(item, "c", ST_INC_L, 1'b0);
            ST_INC_L:    state_in = expect_ch(item, "l", ST_INC_U, 1'b0);
            ST_INC_U:    state_in = expect_ch(item, "u", ST_INC_D, 1'b0);
            ST_INC_D:    state_in = expect_ch(item, "d", ST_INC_E, 1'b0);
            ST_INC_E:    state_in = expect_ch(item, "e", ST_INC_LINE, 1'b0);
            ST_INC_LINE: begin
               if (item.nl) begin
                  state_in = ST_NORMAL;
               end else if (item.lt || item.dquote) begin
                  std_in   = item.lt;
                  pos_in   = '0;
                  mis_in   = 1'b0;
                  state_in = item.lt ? ST_STD_NAME : ST_LOCAL_NAME;
               end
            end
            ST_LOCAL_NAME, ST_STD_NAME: begin
               rsp_beat_in.std_include = std_ff;
               if (item.nl) begin
                  rsp_beat_in.event_res = EV_NAME_DROP;
                  state_in = ST_NORMAL;
               end else if ((state_ff == ST_STD_NAME) ? item.gt : item.dquote) begin
                  rsp_beat_in.event_res        = EV_NAME_END;
                  rsp_beat_in.is_config_header = hit;
                  if (hit) begin
                     has_in = 1'b1;
                  end
                  state_in = ST_SKIP;
               end else begin
                  rsp_beat_in.event_res = EV_NAME_BYTE;
                  rsp_beat_in.name_byte = item.data;
                  if ((pos_ff < HDR_LEN) && (item.data == hdr_char(pos_ff))) begin
                     pos_in = 4'(pos_ff + 4'd1);
                  end else begin
                     mis_in = 1'b1;
                  end
               end
            end
            ST_IF_START: begin
               if (item.nl) begin
                  state_in = ST_NORMAL;
               end else if (item.underscore || item.lower) begin
                  state_in = ST_IF_MID;
               end else if (item.upper) begin
                  state_in = ST_CF_O;
               end
            end
            ST_IF_MID:   state_in = from_mid(item);
            ST_CF_O:     state_in = expect_ch(item, "O", ST_CF_N, 1'b1);
            ST_CF_N:     state_in = expect_ch(item, "N", ST_CF_F, 1'b1);
            ST_CF_F:     state_in = expect_ch(item, "F", ST_CF_I, 1'b1);
            ST_CF_I:     state_in = expect_ch(item, "I", ST_CF_G, 1'b1);
            ST_CF_G:     state_in = expect_ch(item, "G", ST_CF_US, 1'b1);
            ST_CF_US: begin
               if (item.underscore) begin
                  rsp_beat_in.event_res      = EV_CONFIG_USE;
                  rsp_beat_in.config_missing = !has_ff;
                  needs_in = 1'b1;
                  state_in = ST_SKIP;
               end else begin
                  state_in = from_mid(item);
               end
            end
            default:     state_in = from_normal(item);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_NORMAL;
         needs_ff     <= 1'b0;
         has_ff       <= 1'b0;
         pos_ff       <= '0;
         mis_ff       <= 1'b0;
         std_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (item_take) begin
            state_ff <= state_in;
            needs_ff <= needs_in;
            has_ff   <= has_in;
            pos_ff   <= pos_in;
            mis_ff   <= mis_in;
            std_ff   <= std_in;
         end
         if (item_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         rsp_beat_ff <= rsp_beat_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/c_include_config_scanner_top.sv =====
// A request beat is written into the byte queue; the back end then moves its result
// into the output register, from which the result port presents it.
// Throughput: one source byte per cycle while the result port is not stalled.
// A stalled result port backs up the byte queue, then stalls the request port.
// Reset is synchronous and active high; it empties the queue and output register
// and returns the scanner to normal text with all flags cleared.
`default_nettype none
`include "c_include_config_scanner_top_defines.svh"

module c_include_config_scanner_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire                     logic clock,
   input  wire                     logic reset,
   input  wire                     logic req_valid,
   output logic                    req_stall,
   input  wire cics_pkg::req_beat_type req_beat,
   output logic                    rsp_valid,
   input  wire                     logic rsp_stall,
   output cics_pkg::rsp_beat_type  rsp_beat
);
   import cics_pkg::*;

   // The front end turns each request beat into a byte with its class flags
   // already decoded. Those items wait in a short queue so that the request
   // side only stalls once the queue is full.
   cls_type front_cls;
   cls_type queue_head;
   logic    queue_full;
   logic    queue_not_empty;
   logic    queue_pop;
   logic    req_push;

   assign req_stall = queue_full;
   assign req_push  = req_valid && !queue_full;

   cics_front u_front (
      .req_beat (req_beat),
      .cls      (front_cls)
   );

   cics_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_cls),
      .pop       (queue_pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (queue_head)
   );

   // The back end runs the scanner state machine, one item per cycle, and
   // holds each result in an output register. It takes the next item whenever
   // that register is empty or is being drained in the same cycle, so a stall
   // on the response port reaches the request port only once the queue is full.
   cics_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_not_empty),
      .item       (queue_head),
      .item_take  (queue_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_beat   (rsp_beat)
   );

   // The queue can only fill up when the result port held a stalled beat
   // in the cycle before.
   `CICS_ASSERT_IMP(a_stall_from_back, clock, reset, req_stall,
                    $past(rsp_valid && rsp_stall))

   // A name byte appears only on a name byte beat.
   `CICS_ASSERT_IMP(a_name_byte_clean, clock, reset,
                    rsp_valid && (rsp_beat.event_res != EV_NAME_BYTE),
                    rsp_beat.name_byte == 8'h00)

   // The missing-config flag belongs to config use beats only.
   `CICS_ASSERT_IMP(a_missing_clean, clock, reset,
                    rsp_valid && (rsp_beat.event_res != EV_CONFIG_USE),
                    !rsp_beat.config_missing)

   // After an accepted byte has passed the queue and the output register, the result port is holding a beat.
   `CICS_ASSERT_LAT2(a_result_follows, clock, reset, req_valid && !req_stall, rsp_valid)

endmodule

`default_nettype wire

// ===== tb/tb_c_include_config_scanner_top.sv =====
// Self-checking bench for the include and config scanner. Every accepted
// request beat yields exactly one result beat, so a model of the scanner
// runs alongside the block and queues one expected result per request beat.
// Result beats are compared field by field against that queue in order.
module tb_c_include_config_scanner_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cics_pkg::*;

   // Path of the config header, split so the path is assembled here.
   localparam string CFG_HDR = {"li", "nux/config.h"};
   // Cycles without any beat moving before the run is declared hung. The
   // long receiver hold-off below is the longest quiet stretch of a good run.
   localparam int IDLE_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_BEATS = 430;
   localparam int MAX_REPORTS = 10;
   // Clocks to run on after every expected result beat is back.
   localparam int DRAIN_CYCLES = 10;

   // Scanner model and store of expected result beats.
   class scan_scoreboard;
      state_type scan_st = ST_NORMAL;
      bit needs_cfg;
      bit has_cfg;
      bit name_off;
      bit angle_name;
      logic [3:0] match_pos = '0;
      rsp_beat_type expected_q[$];
      int failures;

      function void clear_state();
         scan_st = ST_NORMAL;
         needs_cfg = 1'b0;
         has_cfg = 1'b0;
         name_off = 1'b0;
         angle_name = 1'b0;
         match_pos = '0;
      endfunction

      function bit is_letter(logic [7:0] b);
         return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
      endfunction

      function state_type text_next(logic [7:0] b);
         if (b == CH_SLASH) return ST_SLASH;
         if (b == CH_DQUOTE) return ST_STR;
         if (b == CH_SQUOTE) return ST_CHR;
         if (b == CH_HASH) return ST_PRE;
         return ST_NORMAL;
      endfunction

      function state_type skip_next(logic [7:0] b);
         if (b == CH_NL) return ST_NORMAL;
         if (b == CH_BSLASH) return ST_SKIP_ESC;
         return ST_SKIP;
      endfunction

      function state_type word_next(logic [7:0] b);
         if (b == CH_NL) return ST_NORMAL;
         if (b == CH_UNDERSCORE || is_letter(b)) return ST_IF_MID;
         return ST_IF_START;
      endfunction

      function state_type comment_next(logic [7:0] b);
         return (b == CH_STAR) ? ST_CMT_STAR : ST_CMT;
      endfunction

      // One letter of a fixed keyword; a miss falls back to the line rules.
      function state_type keyword_next(logic [7:0] b, logic [7:0] want, state_type hit,
                                       bit on_if_line);
         if (b == want) return hit;
         return on_if_line ? word_next(b) : skip_next(b);
      endfunction

      function string show(rsp_beat_type r);
         return $sformatf("ev=%0d byte=%02h std=%b hdr=%b miss=%b need=%b has=%b",
                          r.event_res, r.name_byte, r.std_include, r.is_config_header,
                          r.config_missing, r.needs_config_flag, r.has_config_flag);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Advance the model by one accepted request beat.
      function void note_beat(req_beat_type r);
         rsp_beat_type e;
         logic [7:0] b;
         state_type nx;
         bit hit;
         e = '0;
         b = r.data_byte;
         if (r.end_of_file) begin
            e.event_res = EV_FILE_END;
            e.needs_config_flag = needs_cfg;
            e.has_config_flag = has_cfg;
            clear_state();
            expected_q.push_back(e);
            return;
         end
         e.event_res = EV_NONE;
         case (scan_st)
            ST_SLASH: nx = (b == CH_STAR) ? ST_CMT : text_next(b);
            ST_STR: begin
               if (b == CH_DQUOTE) nx = ST_NORMAL;
               else nx = (b == CH_BSLASH) ? ST_STR_ESC : ST_STR;
            end
            ST_STR_ESC: nx = ST_STR;
            ST_CHR: begin
               if (b == CH_SQUOTE) nx = ST_NORMAL;
               else nx = (b == CH_BSLASH) ? ST_CHR_ESC : ST_CHR;
            end
            ST_CHR_ESC: nx = ST_CHR;
            ST_CMT: nx = comment_next(b);
            ST_CMT_STAR: nx = (b == CH_SLASH) ? ST_NORMAL : comment_next(b);
            ST_PRE: begin
               if (b == CH_NL) nx = ST_NORMAL;
               else if (b == CH_SPACE || b == CH_TAB) nx = ST_PRE;
               else if (b == "i") nx = ST_PRE_I;
               else nx = ST_SKIP;
            end
            ST_SKIP: nx = skip_next(b);
            ST_SKIP_ESC: nx = ST_SKIP;
            ST_PRE_I: begin
               if (b == "f") nx = needs_cfg ? ST_SKIP : ST_IF_START;
               else if (b == "n") nx = ST_INC_C;
               else nx = skip_next(b);
            end
            ST_INC_C: nx = keyword_next(b, "c", ST_INC_L, 1'b0);
            ST_INC_L: nx = keyword_next(b, "l", ST_INC_U, 1'b0);
            ST_INC_U: nx = keyword_next(b, "u", ST_INC_D, 1'b0);
            ST_INC_D: nx = keyword_next(b, "d", ST_INC_E, 1'b0);
            ST_INC_E: nx = keyword_next(b, "e", ST_INC_LINE, 1'b0);
            ST_INC_LINE: begin
               if (b == CH_NL) begin
                  nx = ST_NORMAL;
               end else if (b == CH_LT || b == CH_DQUOTE) begin
                  angle_name = (b == CH_LT);
                  match_pos = '0;
                  name_off = 1'b0;
                  nx = (b == CH_LT) ? ST_STD_NAME : ST_LOCAL_NAME;
               end else begin
                  nx = ST_INC_LINE;
               end
            end
            ST_LOCAL_NAME, ST_STD_NAME: begin
               e.std_include = angle_name;
               if (b == CH_NL) begin
                  e.event_res = EV_NAME_DROP;
                  nx = ST_NORMAL;
               end else if (b == ((scan_st == ST_STD_NAME) ? CH_GT : CH_DQUOTE)) begin
                  hit = !name_off && match_pos == HDR_LEN;
                  e.event_res = EV_NAME_END;
                  e.is_config_header = hit;
                  if (hit) has_cfg = 1'b1;
                  nx = ST_SKIP;
               end else begin
                  e.event_res = EV_NAME_BYTE;
                  e.name_byte = b;
                  if (match_pos < HDR_LEN && b == CFG_HDR[match_pos]) match_pos++;
                  else name_off = 1'b1;
                  nx = scan_st;
               end
            end
            ST_IF_START: begin
               if (b == CH_NL) nx = ST_NORMAL;
               else if (b == CH_UNDERSCORE || (b >= "a" && b <= "z")) nx = ST_IF_MID;
               else if (b >= "A" && b <= "Z") nx = ST_CF_O;
               else nx = ST_IF_START;
            end
            ST_IF_MID: nx = word_next(b);
            ST_CF_O: nx = keyword_next(b, "O", ST_CF_N, 1'b1);
            ST_CF_N: nx = keyword_next(b, "N", ST_CF_F, 1'b1);
            ST_CF_F: nx = keyword_next(b, "F", ST_CF_I, 1'b1);
            ST_CF_I: nx = keyword_next(b, "I", ST_CF_G, 1'b1);
            ST_CF_G: nx = keyword_next(b, "G", ST_CF_US, 1'b1);
            ST_CF_US: begin
               if (b == CH_UNDERSCORE) begin
                  e.event_res = EV_CONFIG_USE;
                  e.config_missing = !has_cfg;
                  needs_cfg = 1'b1;
                  nx = ST_SKIP;
               end else begin
                  nx = word_next(b);
               end
            end
            default: nx = text_next(b);
         endcase
         scan_st = nx;
         expected_q.push_back(e);
      endfunction

      // Compare one accepted result beat with the oldest expectation.
      function void check_result(rsp_beat_type got);
         rsp_beat_type want;
         bit bad;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("scan mismatch: result with nothing expected: %s", show(got));
            return;
         end
         want = expected_q.pop_front();
         bad = (got.event_res !== want.event_res) ||
               (got.name_byte !== want.name_byte) ||
               (got.std_include !== want.std_include) ||
               (got.is_config_header !== want.is_config_header) ||
               (got.config_missing !== want.config_missing) ||
               (got.needs_config_flag !== want.needs_config_flag) ||
               (got.has_config_flag !== want.has_config_flag);
         if (bad) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("scan mismatch: expected %s, got %s", show(want), show(got));
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_beat_type req_beat = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_beat_type rsp_beat;

   scan_scoreboard sb = new;

   // Source beats waiting to be offered in the current phase.
   req_beat_type src_q[$];
   // Percent of cycles in which each side idles; the main sequence sets them.
   int snd_pct = 23;
   int rcv_pct = 85;
   // Request for one long receiver hold-off, taken up by the receiver process.
   bit want_hold = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;

   // Fragments of C source used to build the random part of the stream.
   string if_heads [5] = '{"if ", "ifdef ", "ifndef ", "if(", "if\t"};
   string if_words [11] = '{"CONFIG_SMP", "XONFIG_A", "defined", "CONFIG", "CONF1G_X",
                            "_CONFIG_B", "a1CONFIG_C", "9CONFIG_", "config_x", "ZZ",
                            "CONFIGURE_"};
   string if_seps [4] = '{" && ", " ", "(", " || !"};
   string cmt_bits [7] = '{"*", "x", "/", "\n", "#if CONFIG_A", "'", "* /"};
   string str_bits [6] = '{"a", "\\\"", "\\\\", "#include <x>", "/*", "'"};
   string chr_bits [4] = '{"a", "\\'", "\\\\", "\""};
   string line_bits [8] = '{"#define A(x) x \\\n CONFIG_B \\\n + 1\n",
                            "# define B \"q\" \\\n#if CONFIG_C\n", "#error CONFIG_D\n",
                            "#\n", "#i\n", "#ix CONFIG_E\n", "#include\n",
                            "#includeQ \"a\"\n"};
   string code_bits [6] = '{"int a = b / c;\n", "x = y * 2;\n", "p = 'q'; /",
                            "s = \"t\";\n", "z = w/*c*/ + 1;\n", "if (CONFIG_F) f();\n"};
   string name_pool = "abcxyz/._-CONFIGh019";

   c_include_config_scanner_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit roll(int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   function automatic void add_byte(logic [7:0] b);
      req_beat_type r;
      r.data_byte = b;
      r.end_of_file = 1'b0;
      src_q.push_back(r);
   endfunction

   // The byte travelling with an end of file is ignored, so it is random.
   function automatic void add_eof();
      req_beat_type r;
      r.data_byte = 8'($urandom_range(0, 255));
      r.end_of_file = 1'b1;
      src_q.push_back(r);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic void add_blanks(int most);
      repeat ($urandom_range(0, most)) add_byte(roll(50) ? CH_SPACE : CH_TAB);
   endfunction

   function automatic logic [7:0] name_char();
      return name_pool[$urandom_range(0, name_pool.len() - 1)];
   endfunction

   // Append one randomly chosen piece of source. Include lines and #if lines
   // dominate, since they are the only paths that produce name and config events; the rest
   // is comments, literals, continued directives, plain code, raw noise and ends of file.
   function automatic void add_fragment();
      int pick;
      int n;
      int k;
      int cut;
      bit angle;
      pick = $urandom_range(0, 99);
      if (pick < 24) begin
         add_byte(CH_HASH);
         add_blanks(2);
         if (roll(10)) add_text("inclde");
         else add_text("include");
         add_blanks(2);
         angle = roll(50);
         add_byte(angle ? CH_LT : CH_DQUOTE);
         k = $urandom_range(0, 9);
         case (k)
            0, 1, 2, 3: add_text(CFG_HDR);
            4: begin
               // A strict prefix of the header path, possibly empty.
               n = $urandom_range(0, 13);
               for (int i = 0; i < n; i++) add_byte(CFG_HDR[i]);
            end
            5: begin
               // Overlong name: the full path with a tail.
               add_text(CFG_HDR);
               repeat ($urandom_range(1, 3)) add_byte(name_char());
            end
            6: begin
               n = $urandom_range(0, 13);
               for (int i = 0; i < 14; i++) add_byte((i == n) ? name_char() : CFG_HDR[i]);
            end
            default: repeat ($urandom_range(1, 12)) add_byte(name_char());
         endcase
         cut = $urandom_range(0, 9);
         if (cut == 8) begin
            // Name broken by a newline before it is closed.
            add_byte(CH_NL);
         end else begin
            // The closer of the other kind is just another name byte.
            if (cut == 9) add_byte(angle ? CH_DQUOTE : CH_GT);
            add_byte(angle ? CH_GT : CH_DQUOTE);
         end
         add_byte(CH_NL);
      end else if (pick < 44) begin
         add_byte(CH_HASH);
         add_blanks(2);
         add_text(if_heads[$urandom_range(0, $size(if_heads) - 1)]);
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) begin
            if (i > 0) add_text(if_seps[$urandom_range(0, $size(if_seps) - 1)]);
            add_text(if_words[$urandom_range(0, $size(if_words) - 1)]);
         end
         add_byte(CH_NL);
      end else if (pick < 52) begin
         add_text("/*");
         repeat ($urandom_range(0, 8)) add_text(cmt_bits[$urandom_range(0, 6)]);
         add_text("*/");
      end else if (pick < 60) begin
         if (roll(50)) begin
            add_byte(CH_DQUOTE);
            repeat ($urandom_range(0, 6)) add_text(str_bits[$urandom_range(0, 5)]);
            add_byte(CH_DQUOTE);
         end else begin
            add_byte(CH_SQUOTE);
            add_text(chr_bits[$urandom_range(0, 3)]);
            add_byte(CH_SQUOTE);
         end
      end else if (pick < 68) begin
         add_text(line_bits[$urandom_range(0, $size(line_bits) - 1)]);
      end else if (pick < 80) begin
         add_text(code_bits[$urandom_range(0, $size(code_bits) - 1)]);
      end else if (pick < 92) begin
         // Raw bytes over the whole range, NUL and 0xff included.
         repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
      end else begin
         add_eof();
      end
   endfunction

   // Offer every queued beat in order. The sender idles at random between
   // beats, and a beat stays on the port unchanged until it is taken.
   task automatic send_beats();
      foreach (src_q[i]) begin
         while (roll(snd_pct)) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid <= 1'b1;
         req_beat <= src_q[i];
         do @(posedge clock); while (req_stall);
         sb.note_beat(src_q[i]);
      end
      req_valid <= 1'b0;
   endtask

   // One phase of traffic under one idling pattern. Each phase ends with the
   // sender paused until every expected result beat has come back.
   task automatic run_phase(int sender_pct, int receiver_pct, bit hold);
      snd_pct = sender_pct;
      rcv_pct = receiver_pct;
      want_hold = hold;
      while (src_q.size() < PHASE_BEATS) add_fragment();
      send_beats();
      src_q.delete();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Receiver: check each beat taken at this edge, then choose the stall for
   // the next cycle. A requested hold-off keeps the port stalled for a long
   // stretch so that the block's queue fills and the request port stalls.
   always @(posedge clock) begin
      logic nxt_stall;
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_beat);
      if (hold_left > 0) begin
         hold_left--;
         nxt_stall = 1'b1;
      end else if (want_hold) begin
         want_hold = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         nxt_stall = 1'b1;
      end else begin
         nxt_stall = roll(rcv_pct);
      end
      rsp_stall <= nxt_stall;
   end

   // Watchdog: a run in which no beat moves for too long has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: NUL and 0xff as plain text, an #if whose word
      // opens with an uppercase letter other than C but still reports a config
      // use, and an angle include name cut by a newline.
      add_byte(8'h00);
      add_byte(8'hff);
      add_eof();
      add_text("#if XONFIG_\n");
      add_text("#include<a\n");
      add_eof();

      // Sender idles lightly while the receiver stalls heavily, then the
      // reverse, then full rate with one long receiver hold-off.
      run_phase(23, 85, 1'b0);
      run_phase(85, 23, 1'b0);
      run_phase(0, 0, 1'b1);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
